>>> rtl/glyph_color_best_match_ssd_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the glyph colour best-match block
// Same-cycle and next-cycle implication checks on the block clock and reset.
// ---------------------------------------------------------------------------
`ifndef GLYPH_COLOR_BEST_MATCH_SSD_TOP_ASSERT_SVH
`define GLYPH_COLOR_BEST_MATCH_SSD_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define GCBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define GCBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/gcbm_pkg.sv
// ---------------------------------------------------------------------------
// gcbm_pkg
// Shared widths, codes and types of the glyph colour best-match block.
// ---------------------------------------------------------------------------
package gcbm_pkg;

  // field widths
  localparam int GLYPH_W   = 7;
  localparam int COLOUR_W  = 4;
  localparam int CHAN_W    = 8;
  localparam int ERR_W     = 26;
  // three squared 8-bit differences fit in 18 bits
  localparam int PX_W      = 18;
  localparam int CFG_IDX_W = 2;

  localparam logic [ERR_W-1:0]    ERR_MAX    = {ERR_W{1'b1}};
  localparam logic [GLYPH_W-1:0]  GLYPH_LAST = 7'd94;
  localparam logic [COLOUR_W-1:0] BLACK      = 4'd0;
  localparam logic [COLOUR_W-1:0] GREY_DARK  = 4'd7;
  localparam logic [COLOUR_W-1:0] GREY_LIGHT = 4'd8;
  localparam logic [COLOUR_W-1:0] WHITE      = 4'd15;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOUR     = 2'd0,
    REG_BACKGROUND = 2'd1,
    REG_GRAYSCALE  = 2'd2
  } gcbm_reg_e;

  typedef struct packed {
    logic colour_en;
    logic background_en;
    logic grayscale_en;
  } gcbm_cfg_t;

  // candidate identity and framing of one pixel pair
  typedef struct packed {
    logic [GLYPH_W-1:0]  glyph;
    logic [COLOUR_W-1:0] back;
    logic [COLOUR_W-1:0] fore;
    logic                cand_end;
    logic                cell_end;
  } gcbm_tag_t;

  typedef struct packed {
    logic [CHAN_W-1:0] stamp_red;
    logic [CHAN_W-1:0] stamp_green;
    logic [CHAN_W-1:0] stamp_blue;
    logic [CHAN_W-1:0] image_red;
    logic [CHAN_W-1:0] image_green;
    logic [CHAN_W-1:0] image_blue;
  } gcbm_pix_t;

  typedef struct packed {
    logic [GLYPH_W-1:0]  glyph;
    logic [COLOUR_W-1:0] back;
    logic [COLOUR_W-1:0] fore;
    logic [ERR_W-1:0]    error;
  } gcbm_result_t;

endpackage

>>> rtl/glyph_color_best_match_ssd_top.sv
// ---------------------------------------------------------------------------
// glyph_color_best_match_ssd_top
// Best glyph and colour pair for one image cell by sum of squared RGB error.
// ---------------------------------------------------------------------------
// The block takes one pixel pair per cycle. The transfer that carries tlast
// (cell end) lands in the input register, moves on to the squared-difference
// register and then loads the result register, which presents the cell's
// result. The input side stalls only when a cell's result is due while the
// previous result still waits in the output register; the accumulate and
// compare loop on the running error sets the one-item-per-cycle rate.
// Configuration is taken at once on cfg_we_i and needs no clearing pass
// after reset.
module glyph_color_best_match_ssd_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // bits from lsb: glyph_id[6:0], back_colour[10:7], fore_colour[14:11],
  // stamp_red[22:15], stamp_green[30:23], stamp_blue[38:31],
  // image_red[46:39], image_green[54:47], image_blue[62:55], zero[63]
  input  logic [63:0]                    s_axis_tdata,
  // bits from lsb: candidate_end[0]
  input  logic [0:0]                     s_axis_tuser,
  input  logic                           s_axis_tlast,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // bits from lsb: best_glyph[6:0], best_back[10:7], best_fore[14:11],
  // best_error[40:15], zero[47:41]
  output logic [47:0]                    m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_we_i,
  input  logic [gcbm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [0:0]                     cfg_wdata_i
);

  gcbm_pkg::gcbm_cfg_t       cfg_q;
  gcbm_pkg::gcbm_tag_t       in_tag;
  gcbm_pkg::gcbm_pix_t       in_pix;
  gcbm_pkg::gcbm_tag_t       px_tag;
  logic [gcbm_pkg::PX_W-1:0] px;
  logic                      px_valid;
  logic                      stall;
  gcbm_pkg::gcbm_result_t    result;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.colour_en     <= 1'b1;
      cfg_q.background_en <= 1'b1;
      cfg_q.grayscale_en  <= 1'b0;
    end else if (cfg_we_i) begin
      case (gcbm_pkg::gcbm_reg_e'(cfg_idx_i))
        gcbm_pkg::REG_COLOUR:     cfg_q.colour_en     <= cfg_wdata_i[0];
        gcbm_pkg::REG_BACKGROUND: cfg_q.background_en <= cfg_wdata_i[0];
        gcbm_pkg::REG_GRAYSCALE:  cfg_q.grayscale_en  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // unpack the input transfer
  always_comb begin
    in_tag.glyph       = s_axis_tdata[6:0];
    in_tag.back        = s_axis_tdata[10:7];
    in_tag.fore        = s_axis_tdata[14:11];
    in_tag.cand_end    = s_axis_tuser[0];
    in_tag.cell_end    = s_axis_tlast;
    in_pix.stamp_red   = s_axis_tdata[22:15];
    in_pix.stamp_green = s_axis_tdata[30:23];
    in_pix.stamp_blue  = s_axis_tdata[38:31];
    in_pix.image_red   = s_axis_tdata[46:39];
    in_pix.image_green = s_axis_tdata[54:47];
    in_pix.image_blue  = s_axis_tdata[62:55];
  end

  // hold the pipeline only when a result is due and the output slot is busy
  assign stall         = px_valid && px_tag.cell_end && m_axis_tvalid && !m_axis_tready;
  assign s_axis_tready = !stall;

  gcbm_sqdiff u_sqdiff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (!stall),
    .valid_i (s_axis_tvalid),
    .tag_i   (in_tag),
    .pix_i   (in_pix),
    .valid_o (px_valid),
    .tag_o   (px_tag),
    .px_o    (px)
  );

  gcbm_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (!stall),
    .valid_i     (px_valid),
    .tag_i       (px_tag),
    .px_i        (px),
    .cfg_i       (cfg_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (result)
  );

  // pack the result transfer
  assign m_axis_tdata = {7'b0, result.error, result.fore, result.back, result.glyph};

  // checks
  `include "glyph_color_best_match_ssd_top_assert.svh"

  `GCBM_ASSERT_NOW(a_no_winner_zero_ids,
    m_axis_tvalid && (result.error == gcbm_pkg::ERR_MAX),
    (result.glyph == '0) && (result.back == '0) && (result.fore == '0),
    "result without a winner carries nonzero candidate fields")
  `GCBM_ASSERT_NOW(a_stall_only_when_full,
    !s_axis_tready,
    m_axis_tvalid && !m_axis_tready && px_valid && px_tag.cell_end,
    "input stalled while the output slot could take a result")
  `GCBM_ASSERT_NEXT(a_result_from_cell_end,
    !(px_valid && px_tag.cell_end && !stall) && !(m_axis_tvalid && !m_axis_tready),
    !m_axis_tvalid,
    "result transfer appeared without a cell end")

endmodule

>>> rtl/gcbm_sqdiff.sv
// ---------------------------------------------------------------------------
// gcbm_sqdiff
// Input register and squared RGB error stage of the best-match pipeline.
// ---------------------------------------------------------------------------
module gcbm_sqdiff (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  gcbm_pkg::gcbm_tag_t      tag_i,
  input  gcbm_pkg::gcbm_pix_t      pix_i,
  output logic                     valid_o,
  output gcbm_pkg::gcbm_tag_t      tag_o,
  output logic [gcbm_pkg::PX_W-1:0] px_o
);

  logic                      in_valid_q;
  gcbm_pkg::gcbm_tag_t       in_tag_q;
  gcbm_pkg::gcbm_pix_t       in_pix_q;
  logic                      px_valid_q;
  gcbm_pkg::gcbm_tag_t       px_tag_q;
  logic [gcbm_pkg::PX_W-1:0] px_q;
  logic [gcbm_pkg::PX_W-1:0] px_d;

  function automatic logic [2*gcbm_pkg::CHAN_W-1:0] sq_diff(
    input logic [gcbm_pkg::CHAN_W-1:0] a,
    input logic [gcbm_pkg::CHAN_W-1:0] b
  );
    logic [gcbm_pkg::CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {{gcbm_pkg::CHAN_W{1'b0}}, d} * {{gcbm_pkg::CHAN_W{1'b0}}, d};
  endfunction

  // valid bits of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      px_valid_q <= 1'b0;
    end else if (en_i) begin
      in_valid_q <= valid_i;
      px_valid_q <= in_valid_q;
    end
  end

  // payload of both stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_tag_q <= tag_i;
      in_pix_q <= pix_i;
      px_tag_q <= in_tag_q;
      px_q     <= px_d;
    end
  end

  // sum of the three channel squares
  always_comb begin
    px_d = gcbm_pkg::PX_W'(sq_diff(in_pix_q.stamp_red, in_pix_q.image_red))
         + gcbm_pkg::PX_W'(sq_diff(in_pix_q.stamp_green, in_pix_q.image_green))
         + gcbm_pkg::PX_W'(sq_diff(in_pix_q.stamp_blue, in_pix_q.image_blue));
  end

  assign valid_o = px_valid_q;
  assign tag_o   = px_tag_q;
  assign px_o    = px_q;

endmodule

>>> rtl/gcbm_search.sv
// ---------------------------------------------------------------------------
// gcbm_search
// Error accumulation, legality check, best-candidate tracking, result register.
// ---------------------------------------------------------------------------
module gcbm_search (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  gcbm_pkg::gcbm_tag_t       tag_i,
  input  logic [gcbm_pkg::PX_W-1:0] px_i,
  input  gcbm_pkg::gcbm_cfg_t       cfg_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output gcbm_pkg::gcbm_result_t    out_data_o
);

  logic [gcbm_pkg::ERR_W-1:0]    running_q, running_d;
  logic [gcbm_pkg::ERR_W-1:0]    lowest_q, lowest_d;
  logic [gcbm_pkg::GLYPH_W-1:0]  glyph_q, glyph_d;
  logic [gcbm_pkg::COLOUR_W-1:0] back_q, back_d;
  logic [gcbm_pkg::COLOUR_W-1:0] fore_q, fore_d;
  logic                          out_valid_q, out_valid_d;
  gcbm_pkg::gcbm_result_t        out_q, out_d;
  logic [gcbm_pkg::ERR_W:0]      sum_wide;
  logic [gcbm_pkg::ERR_W-1:0]    sum_sat;
  logic                          judge;
  logic                          win;
  logic                          take;

  function automatic logic grey_ok(
    input logic [gcbm_pkg::COLOUR_W-1:0] c,
    input logic                          gray
  );
    return (c inside {gcbm_pkg::BLACK, gcbm_pkg::WHITE}) ||
           (gray && (c inside {gcbm_pkg::GREY_DARK, gcbm_pkg::GREY_LIGHT}));
  endfunction

  function automatic logic legal(
    input gcbm_pkg::gcbm_tag_t t,
    input gcbm_pkg::gcbm_cfg_t c
  );
    logic ok;
    ok = (t.glyph <= gcbm_pkg::GLYPH_LAST);
    // a blank glyph shows background only, so foreground must be black
    if (t.glyph != '0 && t.back == t.fore) ok = 1'b0;
    if (t.glyph == '0 && t.fore != gcbm_pkg::BLACK) ok = 1'b0;
    if (!c.background_en && t.back != gcbm_pkg::BLACK) ok = 1'b0;
    if (!c.colour_en && !(grey_ok(t.back, c.grayscale_en) &&
                          grey_ok(t.fore, c.grayscale_en))) ok = 1'b0;
    return ok;
  endfunction

  // saturating accumulate, judge at the candidate end, emit at the cell end
  always_comb begin
    take     = en_i && valid_i;
    sum_wide = {1'b0, running_q} + {{(gcbm_pkg::ERR_W+1-gcbm_pkg::PX_W){1'b0}}, px_i};
    sum_sat  = sum_wide[gcbm_pkg::ERR_W] ? gcbm_pkg::ERR_MAX
                                         : sum_wide[gcbm_pkg::ERR_W-1:0];
    judge    = tag_i.cand_end || tag_i.cell_end;
    win      = judge && legal(tag_i, cfg_i) && (sum_sat < lowest_q);

    running_d = judge ? '0 : sum_sat;
    lowest_d  = win ? sum_sat     : lowest_q;
    glyph_d   = win ? tag_i.glyph : glyph_q;
    back_d    = win ? tag_i.back  : back_q;
    fore_d    = win ? tag_i.fore  : fore_q;

    out_d.glyph = glyph_d;
    out_d.back  = back_d;
    out_d.fore  = fore_d;
    out_d.error = lowest_d;

    if (tag_i.cell_end) begin
      lowest_d = gcbm_pkg::ERR_MAX;
      glyph_d  = '0;
      back_d   = '0;
      fore_d   = '0;
    end

    out_valid_d = out_valid_q && !out_ready_i;
    if (take && tag_i.cell_end) out_valid_d = 1'b1;
  end

  // search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
      lowest_q  <= gcbm_pkg::ERR_MAX;
      glyph_q   <= '0;
      back_q    <= '0;
      fore_q    <= '0;
    end else if (take) begin
      running_q <= running_d;
      lowest_q  <= lowest_d;
      glyph_q   <= glyph_d;
      back_q    <= back_d;
      fore_q    <= fore_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && tag_i.cell_end) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
